// ===== src/dnlp_pkg.sv =====
// shared types and constants for the delimited number list parser
`default_nettype none
package dnlp_pkg;

	// result kinds
	localparam logic [1:0] KIND_NUM  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// configuration register indexes
	localparam logic CFG_MAX_COUNT   = 1'b0;
	localparam logic CFG_VALUE_LIMIT = 1'b1;

	// register reset values
	localparam logic [7:0]  RST_MAX_COUNT   = 8'd3;
	localparam logic [13:0] RST_VALUE_LIMIT = 14'd9999;

	// hard upper bound on a number and the ascii zero digit
	localparam logic [13:0] ABS_LIMIT = 14'd9999;
	localparam logic [7:0]  CH_ZERO   = 8'h30;

	// result queue depth and its fill count width
	localparam int Q_DEPTH = 3;
	localparam int QCNT_W  = 2;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} dnlp_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] value;
		logic [7:0]  index;
		logic [7:0]  count;
		logic [15:0] end_offset;
		logic        last;
	} dnlp_res_t;

endpackage
`default_nettype wire

// ===== src/dnlp_step.sv =====
// parser state registers and the per-byte next-state and result logic
`default_nettype none
module dnlp_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire dnlp_pkg::dnlp_in_t item,
	input  wire logic [7:0]        max_count,
	input  wire logic [13:0]       value_limit,
	output dnlp_pkg::dnlp_res_t    res0,
	output dnlp_pkg::dnlp_res_t    res1,
	output logic [1:0]             push_n
);
	import dnlp_pkg::*;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_LEAD,
		PH_NUM,
		PH_DELIM,
		PH_TRAIL
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [13:0] acc_q, acc, acc_n, acc_base, lim;
	logic [7:0]  cnt_q, cnt, cnt_n;
	logic [7:0]  rem_q, rem, rem_n;
	logic [15:0] off_q, off, off_n, cur;
	logic [7:0]  ch_diff;
	logic [3:0]  dig;
	logic [16:0] prod;
	logic        is_ws, is_digit, is_punct, too_big, trail, take_digit;
	logic [1:0]  n;
	dnlp_res_t   r0, r1, fin;

	// byte classes
	always_comb begin
		is_ws    = (item.ch == 8'h20) || (item.ch >= 8'h09 && item.ch <= 8'h0D);
		is_digit = (item.ch >= CH_ZERO) && (item.ch <= 8'h39);
		is_punct = (item.ch >= 8'h21 && item.ch <= 8'h2F) ||
			(item.ch >= 8'h3A && item.ch <= 8'h40) ||
			(item.ch >= 8'h5B && item.ch <= 8'h60) ||
			(item.ch >= 8'h7B && item.ch <= 8'h7E);
		ch_diff  = item.ch - CH_ZERO;
		dig      = ch_diff[3:0];
	end

	// next state and up to two results for the byte in the input register
	always_comb begin
		ph  = phase_q;
		acc = acc_q;
		cnt = cnt_q;
		rem = rem_q;
		off = off_q;
		if (item.start_req) begin
			ph  = PH_LEAD;
			acc = '0;
			cnt = '0;
			rem = max_count;
			off = '0;
		end
		cur   = off;
		ph_n  = ph;
		acc_n = acc;
		cnt_n = cnt;
		rem_n = rem;
		off_n = off;
		n     = 2'd0;
		r0    = '0;
		r1    = '0;
		fin   = '0;
		trail = 1'b0;
		take_digit = 1'b0;

		// times ten plus the new digit, checked against the effective limit
		acc_base = (ph == PH_NUM) ? acc : '0;
		prod     = ({3'b000, acc_base} << 3) + ({3'b000, acc_base} << 1) + {13'd0, dig};
		lim      = (value_limit < ABS_LIMIT) ? value_limit : ABS_LIMIT;
		too_big  = prod > {3'b000, lim};

		if (ph != PH_DONE) begin
			off_n = (off != 16'hFFFF) ? off + 16'd1 : off;
			case (ph)
				PH_LEAD: begin
					if (is_digit) begin
						take_digit = 1'b1;
					end else if (!is_ws) begin
						trail = 1'b1;
					end
				end
				PH_DELIM: begin
					if (is_digit) begin
						take_digit = 1'b1;
					end else begin
						trail = 1'b1;
					end
				end
				PH_NUM: begin
					if (is_digit) begin
						take_digit = 1'b1;
					end else begin
						r0.kind  = KIND_NUM;
						r0.value = acc;
						r0.index = cnt;
						r0.count = cnt + 8'd1;
						n        = 2'd1;
						cnt_n    = cnt + 8'd1;
						if (is_punct && rem > 8'd1) begin
							rem_n = rem - 8'd1;
							ph_n  = PH_DELIM;
						end else begin
							rem_n = '0;
							trail = 1'b1;
						end
					end
				end
				PH_TRAIL: begin
					trail = 1'b1;
				end
				default: begin
				end
			endcase

			// digit: grow the number or stop with an error
			if (take_digit) begin
				if (too_big) begin
					r0.kind       = KIND_ERR;
					r0.count      = cnt;
					r0.end_offset = cur;
					n             = 2'd1;
					ph_n          = PH_DONE;
				end else begin
					acc_n = prod[13:0];
					ph_n  = PH_NUM;
				end
			end

			// after the list: skip whitespace, first other byte finishes
			if (trail) begin
				if (!is_ws) begin
					fin.kind       = KIND_DONE;
					fin.count      = cnt_n;
					fin.end_offset = cur;
					ph_n           = PH_DONE;
					if (n == 2'd0) begin
						r0 = fin;
					end else begin
						r1 = fin;
					end
					n = n + 2'd1;
				end else begin
					ph_n = PH_TRAIL;
				end
			end

			// mark the final result of this byte
			if (n == 2'd1) begin
				r0.last = 1'b1;
			end else if (n == 2'd2) begin
				r1.last = 1'b1;
			end
		end
	end

	assign res0   = r0;
	assign res1   = r1;
	assign push_n = go ? n : 2'd0;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			acc_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
		end else if (go) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			rem_q   <= rem_n;
			off_q   <= off_n;
		end
	end

`ifndef SYNTH
	// a byte that gives two results ends a number and then finishes the parse
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(n == 2'd2) |-> (r0.kind == KIND_NUM && r1.kind == KIND_DONE))
		else $error("two results not a number followed by finish");

	// the held number never passes the hard bound
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ABS_LIMIT)
		else $error("accumulator above hard bound");

	// with no parse running and no start, a byte changes nothing
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(go && phase_q == PH_DONE && !item.start_req) |=> (phase_q == PH_DONE && $stable(off_q)))
		else $error("idle byte changed parser state");
`endif

endmodule
`default_nettype wire

// ===== src/dnlp_resq.sv =====
// three-entry shifting result queue feeding the output channel
`default_nettype none
module dnlp_resq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_n,
	input  wire dnlp_pkg::dnlp_res_t res0,
	input  wire dnlp_pkg::dnlp_res_t res1,
	output logic                    space,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dnlp_pkg::dnlp_res_t     out_data
);
	import dnlp_pkg::*;

	dnlp_res_t         q_q [Q_DEPTH];
	dnlp_res_t         shifted [Q_DEPTH];
	dnlp_res_t         nq [Q_DEPTH];
	logic [QCNT_W-1:0] count_q, base, count_n;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign out_data  = q_q[0];
	assign pop       = out_valid && !out_stall;
	// room for a byte that gives two results
	assign space     = (count_q <= QCNT_W'(Q_DEPTH - 2));

	// entries move one slot toward the head on a transfer
	always_comb begin
		for (int i = 0; i < Q_DEPTH - 1; i++) begin
			shifted[i] = q_q[i + 1];
		end
		shifted[Q_DEPTH-1] = q_q[Q_DEPTH-1];
	end

	// new results land right after the surviving entries
	always_comb begin
		base    = count_q - QCNT_W'(pop);
		count_n = base + push_n;
		for (int i = 0; i < Q_DEPTH; i++) begin
			if (QCNT_W'(i) < base) begin
				nq[i] = pop ? shifted[i] : q_q[i];
			end else if (QCNT_W'(i) == base) begin
				nq[i] = res0;
			end else if (QCNT_W'(i) == base + QCNT_W'(1)) begin
				nq[i] = res1;
			end else begin
				nq[i] = q_q[i];
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			q_q[i] <= nq[i];
		end
	end

`ifndef SYNTH
	// never more entries than slots
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(Q_DEPTH))
		else $error("result queue overfilled");

	// results arrive only when two slots are free
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> space)
		else $error("results pushed without room");

	// fill count follows pushes and transfers
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) - QCNT_W'($past(pop)) + $past(push_n)))
		else $error("result queue count mismatch");
`endif

endmodule
`default_nettype wire

// ===== src/delimited_number_list_parser.sv =====
// top level: config registers, input register, parser step and result queue
// path: input register, then parser step into the registered result queue
// throughput: one byte per cycle while results drain at one per cycle;
//   a byte giving two results drains from the queue one at a time
// reset: parser waits for a start byte; max_count 3, value_limit 9999
`default_nettype none
module delimited_number_list_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire dnlp_pkg::dnlp_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output dnlp_pkg::dnlp_res_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [13:0]         cfg_data
);
	import dnlp_pkg::*;

	logic [7:0]  max_count_q;
	logic [13:0] value_limit_q;
	dnlp_in_t    item_s1;
	logic        valid_s1;
	logic        go, space, in_take;
	dnlp_res_t   res0, res1;
	logic [1:0]  push_n;

	// a held byte moves on when the queue can take two results
	assign go       = valid_s1 && space;
	assign in_stall = valid_s1 && !space;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q   <= RST_MAX_COUNT;
			value_limit_q <= RST_VALUE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_COUNT:   max_count_q   <= cfg_data[7:0];
				CFG_VALUE_LIMIT: value_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	dnlp_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.item        (item_s1),
		.max_count   (max_count_q),
		.value_limit (value_limit_q),
		.res0        (res0),
		.res1        (res1),
		.push_n      (push_n)
	);

	dnlp_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/sv/delimited_number_list_parser_tb.sv =====
// testbench for the delimited number list parser: random and directed strings, self-checking
module delimited_number_list_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dnlp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [2:0] {S_IDLE, S_LEAD, S_NUM, S_DELIM, S_TRAIL} parse_phase_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	dnlp_in_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	dnlp_res_t   out_data;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [13:0] cfg_data  = '0;

	// byte stream to send and results still owed by the block
	dnlp_in_t  pending_bytes[$];
	dnlp_res_t pending_results[$];

	// parser state as the block should hold it
	parse_phase_t ph        = S_IDLE;
	logic [13:0]  acc       = '0;
	logic [7:0]   nparsed   = '0;
	logic [7:0]   slots     = '0;
	logic [15:0]  next_off  = '0;
	logic [7:0]   cfg_max   = RST_MAX_COUNT;
	logic [13:0]  cfg_limit = RST_VALUE_LIMIT;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  hold_req       = 0;
	int  hold_seen      = 0;
	int  hold_left      = 0;
	bit  in_took        = 1'b0;
	bit  gen_first      = 1'b0;
	int  gen_count      = 0;
	int  quiet          = 0;
	int  err_cnt        = 0;
	int  n_bytes        = 0;
	int  n_num          = 0;
	int  n_done         = 0;
	int  n_err          = 0;

	delimited_number_list_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #10 clk = ~clk;

	// character classes
	function automatic bit is_ws(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	function automatic bit is_punct(logic [7:0] c);
		return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
			(c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
	endfunction

	function automatic dnlp_res_t make_result(logic [1:0] k, logic [13:0] v, logic [7:0] ix,
			logic [7:0] n, logic [15:0] off);
		dnlp_res_t r;
		r.kind       = k;
		r.value      = v;
		r.index      = ix;
		r.count      = n;
		r.end_offset = off;
		r.last       = 1'b0;
		return r;
	endfunction

	// append a digit to the number, 0 when it would pass the limit
	function automatic bit take_digit(logic [7:0] c);
		int lim;
		int v;
		lim = (cfg_limit < ABS_LIMIT) ? int'(cfg_limit) : int'(ABS_LIMIT);
		v = int'(acc) * 10 + (int'(c) - int'(CH_ZERO));
		if (v > lim)
			return 1'b0;
		acc = v[13:0];
		return 1'b1;
	endfunction

	// advance the parser by one byte and queue the results it owes
	task automatic parse_step(input dnlp_in_t b);
		logic [7:0]  c;
		logic [15:0] here;
		bit          trail;
		bit          ovf;
		dnlp_res_t   res[2];
		int          n;
		c = b.ch;
		trail = 1'b0;
		ovf = 1'b0;
		n = 0;
		if (b.start_req) begin
			ph = S_LEAD;
			acc = '0;
			nparsed = '0;
			slots = cfg_max;
			next_off = '0;
		end
		if (ph == S_IDLE)
			return;
		here = next_off;
		if (next_off != 16'hFFFF)
			next_off++;
		case (ph)
			S_LEAD: begin
				if (is_digit(c)) begin
					acc = '0;
					ph = S_NUM;
					ovf = !take_digit(c);
				end else if (!is_ws(c)) begin
					trail = 1'b1;
				end
			end
			S_NUM: begin
				if (is_digit(c)) begin
					ovf = !take_digit(c);
				end else begin
					res[n] = make_result(KIND_NUM, acc, nparsed, nparsed + 8'd1, '0);
					n++;
					nparsed++;
					if (is_punct(c) && slots > 8'd1) begin
						slots--;
						ph = S_DELIM;
					end else begin
						slots = '0;
						trail = 1'b1;
					end
				end
			end
			S_DELIM: begin
				if (is_digit(c)) begin
					acc = '0;
					ph = S_NUM;
					ovf = !take_digit(c);
				end else begin
					trail = 1'b1;
				end
			end
			default: trail = 1'b1;
		endcase
		if (ovf) begin
			res[0] = make_result(KIND_ERR, '0, '0, nparsed, here);
			n = 1;
			ph = S_IDLE;
		end else if (trail) begin
			if (!is_ws(c)) begin
				res[n] = make_result(KIND_DONE, '0, '0, nparsed, here);
				n++;
				ph = S_IDLE;
			end else begin
				ph = S_TRAIL;
			end
		end
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(res[i]);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// stimulus building
	task automatic put_ch(input logic [7:0] c);
		dnlp_in_t b;
		b.ch = c;
		b.start_req = gen_first;
		gen_first = 1'b0;
		gen_count++;
		pending_bytes.push_back(b);
	endtask

	function automatic logic [7:0] pick_punct();
		logic [7:0] c;
		do c = 8'($urandom_range(33, 126)); while (!is_punct(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_ws();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
	endfunction

	function automatic logic [7:0] pick_other();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (is_ws(c) || is_digit(c) || is_punct(c));
		return c;
	endfunction

	// number sizes weighted toward the limit edge and beyond
	function automatic int pick_value();
		int eff;
		eff = (cfg_limit < ABS_LIMIT) ? int'(cfg_limit) : int'(ABS_LIMIT);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 9);
			1: return $urandom_range(10, 99);
			2: return $urandom_range(100, 9999);
			3: return (eff > 0) ? eff - 1 + $urandom_range(0, 2) : $urandom_range(0, 1);
			4: return $urandom_range(10000, 99999);
			default: return $urandom_range(0, eff);
		endcase
	endfunction

	task automatic put_number(input int v);
		string s;
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0)
			put_ch(CH_ZERO);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	// one string: mostly well formed lists, some noise and broken ones
	task automatic gen_string();
		int sel;
		int mc;
		int cap;
		int nnum;
		sel = $urandom_range(0, 99);
		gen_first = 1'b1;
		if (sel < 75) begin
			repeat ($urandom_range(0, 2)) put_ch(pick_ws());
			mc = (cfg_max == 0) ? 1 : int'(cfg_max);
			cap = (mc < 6) ? mc + 1 : 6;
			nnum = $urandom_range(1, cap);
			for (int i = 0; i < nnum; i++) begin
				if (i > 0)
					put_ch(pick_punct());
				if ($urandom_range(0, 19) == 0)
					put_ch(pick_punct());
				put_number(pick_value());
			end
			repeat ($urandom_range(0, 2)) put_ch(pick_ws());
			case ($urandom_range(0, 3))
				0: put_ch(8'h00);
				1: put_ch(pick_punct());
				2: put_ch(pick_other());
				default: put_ch(8'($urandom_range(0, 255)));
			endcase
			repeat ($urandom_range(0, 2)) put_ch(8'($urandom_range(0, 255)));
		end else if (sel < 90) begin
			repeat ($urandom_range(1, 8)) begin
				gen_first = ($urandom_range(0, 3) == 0);
				put_ch(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(2, 10))
				case ($urandom_range(0, 3))
					0: put_ch(CH_ZERO + 8'($urandom_range(0, 9)));
					1: put_ch(pick_punct());
					2: put_ch(pick_ws());
					default: put_ch(pick_other());
				endcase
		end
	endtask

	task automatic gen_random(input int nbytes);
		gen_count = 0;
		while (gen_count < nbytes)
			gen_string();
	endtask

	task automatic write_reg(input logic idx, input logic [13:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_COUNT)
			cfg_max = val[7:0];
		else
			cfg_limit = val;
	endtask

	task automatic set_regs(input logic [7:0] mc, input logic [13:0] lim, input int idle_pct,
			input int stall_pct);
		write_reg(CFG_MAX_COUNT, 14'(mc));
		write_reg(CFG_VALUE_LIMIT, lim);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// wait until every byte is sent and every result has come, then let the pipe settle
	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// sender: next byte after a transfer or an idle cycle
	always @(negedge clk) begin
		dnlp_in_t nxt;
		if (!in_valid || in_took) begin
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_bytes.pop_front();
				in_data <= nxt;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// check result transfers, then predict from the input transfer of the same edge
	always @(posedge clk) begin
		dnlp_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got kind %0d value %0d count %0d",
						$time, out_data.kind, out_data.value, out_data.count);
				end else begin
					want = pending_results.pop_front();
					check_field("kind", 16'(want.kind), 16'(out_data.kind));
					check_field("value", 16'(want.value), 16'(out_data.value));
					check_field("index", 16'(want.index), 16'(out_data.index));
					check_field("count", 16'(want.count), 16'(out_data.count));
					check_field("end_offset", want.end_offset, out_data.end_offset);
					check_field("last", 16'(want.last), 16'(out_data.last));
					if (want.kind == KIND_NUM)
						n_num++;
					else if (want.kind == KIND_DONE)
						n_done++;
					else
						n_err++;
				end
			end
			if (in_valid && !in_stall) begin
				n_bytes++;
				parse_step(in_data);
			end
		end
		in_took <= arst_n && in_valid && !in_stall;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, quiet, pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed strings at reset settings
		gen_first = 1'b0;
		put_ch(CH_ZERO + 8'd7);
		gen_first = 1'b1;
		put_ch(8'h20);
		put_ch(8'h09);
		put_ch(CH_ZERO);
		put_ch(",");
		repeat (4) put_ch(CH_ZERO + 8'd9);
		put_ch(";");
		put_ch(CH_ZERO + 8'd1);
		put_ch(CH_ZERO + 8'd2);
		put_ch("!");
		gen_first = 1'b1;
		put_ch(CH_ZERO + 8'd8);
		gen_first = 1'b1;
		put_ch(CH_ZERO + 8'd5);
		repeat (4) put_ch(CH_ZERO + 8'd9);
		put_ch(8'hFF);
		gen_first = 1'b1;
		put_ch(8'h00);
		gen_first = 1'b1;
		put_ch(8'hFF);
		gen_first = 1'b1;
		put_ch(CH_ZERO + 8'd4);
		put_ch(8'h0D);
		put_ch(8'h0B);
		put_ch("x");
		drain();

		// one number per string, no idling
		set_regs(8'd1, 14'd9999, 0, 0);
		gen_random(80);
		drain();

		// widest list with a zero limit, sender idling
		set_regs(8'd255, 14'd0, 58, 0);
		gen_first = 1'b1;
		repeat (255) begin
			put_ch(CH_ZERO);
			put_ch(",");
		end
		gen_random(80);
		drain();

		// zero count and a limit above the hard bound, receiver stalling
		set_regs(8'd0, 14'h3FFF, 0, 58);
		gen_random(80);
		drain();

		// both sides idling
		set_regs(8'd4, 14'd500, 20, 20);
		gen_random(80);
		drain();

		// long receiver hold while the sender keeps offering
		set_regs(8'd8, 14'd9999, 0, 0);
		gen_random(80);
		hold_req++;
		drain();

		set_regs(8'd7, 14'd9998, 20, 20);
		gen_random(60);
		drain();

		$display("covered %0d input bytes and %0d results: %0d numbers, %0d finished, %0d errors",
			n_bytes, n_num + n_done + n_err, n_num, n_done, n_err);
		$display("seven register settings with count 0/1/255, limit 0/16383, idle mixes and a hold");
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dnlp_pkg.sv
src/dnlp_step.sv
src/dnlp_resq.sv
src/delimited_number_list_parser.sv
tb/sv/delimited_number_list_parser_tb.sv
